### rtl/fmvsw_pkg.sv
// Shared types, constants and tables for the FM chip volume shadow writer.
`default_nettype none

package fmvsw_pkg;

  localparam logic [1:0] REQ_WRITE  = 2'd0;
  localparam logic [1:0] REQ_VOLUME = 2'd1;
  localparam logic [1:0] REQ_MUTE   = 2'd2;

  localparam logic [1:0] LOAD_PASS = 2'd0;
  localparam logic [1:0] LOAD_MIX  = 2'd1;
  localparam logic [1:0] LOAD_SLOT = 2'd2;

  localparam logic [8:0] MIXER_ADDR  = 9'h007;
  localparam logic [7:0] MIXER_RESET = 8'h3F;
  localparam logic [7:0] MIXER_MUTE  = 8'h3F;
  localparam logic [7:0] TL_RESET    = 8'h7F;
  localparam logic [6:0] LEVEL_MAX   = 7'h7F;
  localparam logic [3:0] TL_GROUP    = 4'h4;
  localparam logic [5:0] ALG_GROUP   = 6'b101100;
  localparam logic signed [7:0] MUTE_VOLUME = -8'sd127;
  localparam logic [2:0] LAST_MUTE_CH = 3'd5;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [8:0]        reg_addr;
    logic [7:0]        reg_data;
    logic [2:0]        channel;
    logic signed [7:0] volume;
    logic              mute_on;
  } req_beat_t;

  typedef struct packed {
    logic [8:0] out_addr;
    logic [7:0] out_data;
    logic       last_write;
  } wr_beat_t;

  typedef struct packed {
    logic       capture;
    logic       shadow_wr;
    logic       load;
    logic [1:0] sel;
    logic [1:0] slot;
    logic [2:0] idx;
    logic       mute_mode;
    logic       last;
  } cmd_t;

  typedef struct packed {
    logic enable;
    logic out_free;
    logic mask_bit;
  } sts_t;

  function automatic logic [3:0] carrier_mask(input logic [2:0] alg);
    case (alg)
      3'd0, 3'd1, 3'd2, 3'd3: carrier_mask = 4'h8;
      3'd4:                   carrier_mask = 4'hC;
      3'd5, 3'd6:             carrier_mask = 4'hE;
      default:                carrier_mask = 4'hF;
    endcase
  endfunction

endpackage

`default_nettype wire

### rtl/fmvsw_ctrl.sv
// Request sequencer: walks pass-through, mixer and carrier-slot writes.
`default_nettype none

module fmvsw_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             req_valid,
  input  wire logic [1:0]       req_type,
  output logic                  req_stall,
  output fmvsw_pkg::cmd_t       cmd,
  input  wire fmvsw_pkg::sts_t  sts
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_PASS = 2'd1;
  localparam logic [1:0] ST_MIX  = 2'd2;
  localparam logic [1:0] ST_SLOT = 2'd3;

  logic [1:0] state, state_next;
  logic [1:0] slot, slot_next;
  logic [2:0] idx, idx_next;
  logic       mute_mode, mute_mode_next;
  logic       accept;
  logic       done;

  assign req_stall = (state != ST_IDLE);
  assign accept    = req_valid && !req_stall;
  assign done      = (slot == 2'd3) && (!mute_mode || idx == fmvsw_pkg::LAST_MUTE_CH);

  always_comb begin
    state_next     = state;
    slot_next      = slot;
    idx_next       = idx;
    mute_mode_next = mute_mode;
    cmd            = '0;
    cmd.capture    = accept;
    cmd.slot       = slot;
    cmd.idx        = idx;
    cmd.mute_mode  = mute_mode;
    case (state)
      ST_IDLE: begin
        if (accept && sts.enable) begin
          cmd.shadow_wr = (req_type == fmvsw_pkg::REQ_WRITE);
          slot_next      = 2'd0;
          idx_next       = 3'd0;
          case (req_type)
            fmvsw_pkg::REQ_WRITE: state_next = ST_PASS;
            fmvsw_pkg::REQ_VOLUME: begin
              state_next     = ST_SLOT;
              mute_mode_next = 1'b0;
            end
            fmvsw_pkg::REQ_MUTE: begin
              state_next     = ST_MIX;
              mute_mode_next = 1'b1;
            end
            default: state_next = ST_IDLE;
          endcase
        end
      end
      ST_PASS: begin
        cmd.sel  = fmvsw_pkg::LOAD_PASS;
        cmd.last = 1'b1;
        if (sts.out_free) begin
          cmd.load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_MIX: begin
        cmd.sel = fmvsw_pkg::LOAD_MIX;
        if (sts.out_free) begin
          cmd.load   = 1'b1;
          state_next = ST_SLOT;
        end
      end
      ST_SLOT: begin
        cmd.sel  = fmvsw_pkg::LOAD_SLOT;
        cmd.last = done;
        if (!sts.mask_bit || sts.out_free) begin
          cmd.load = sts.mask_bit;
          if (slot == 2'd3) begin
            slot_next = 2'd0;
            if (done) begin
              state_next = ST_IDLE;
            end else begin
              idx_next = idx + 3'd1;
            end
          end else begin
            slot_next = slot + 2'd1;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      slot      <= 2'd0;
      idx       <= 3'd0;
      mute_mode <= 1'b0;
    end else begin
      state     <= state_next;
      slot      <= slot_next;
      idx       <= idx_next;
      mute_mode <= mute_mode_next;
    end
  end

endmodule

`default_nettype wire

### rtl/fmvsw_datapath.sv
// Shadow registers, level arithmetic and output beat register.
`default_nettype none

module fmvsw_datapath (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_wr_en,
  input  wire logic                 cfg_wr_data,
  input  wire fmvsw_pkg::req_beat_t req,
  input  wire fmvsw_pkg::cmd_t      cmd,
  output fmvsw_pkg::sts_t           sts,
  output logic                      wr_valid,
  input  wire logic                 wr_stall,
  output fmvsw_pkg::wr_beat_t       wr
);

  logic       chip_enable;
  logic [7:0] tl_shadow [32];
  logic [7:0] alg_shadow [8];
  logic [7:0] mixer_shadow;

  logic [8:0]        addr_q;
  logic [7:0]        data_q;
  logic [2:0]        ch_q;
  logic signed [7:0] vol_q;
  logic              mute_q;

  logic [2:0]        ch_sel;
  logic signed [7:0] vol_sel;
  logic [3:0]        mask;
  logic [6:0]        tl7;
  logic [9:0]        diff;
  logic [6:0]        level;
  fmvsw_pkg::wr_beat_t beat;

  assign ch_sel  = cmd.mute_mode ? {cmd.idx[0], cmd.idx[2:1]} : ch_q;
  assign vol_sel = cmd.mute_mode ? (mute_q ? fmvsw_pkg::MUTE_VOLUME : 8'sd0) : vol_q;
  assign mask    = fmvsw_pkg::carrier_mask(alg_shadow[ch_sel][2:0]);
  assign tl7     = tl_shadow[{ch_sel[2], cmd.slot, ch_sel[1:0]}][6:0];
  assign diff    = {3'b000, tl7} - {{2{vol_sel[7]}}, vol_sel};

  always_comb begin
    if (diff[9]) begin
      level = 7'd0;
    end else if (diff[8:7] != 2'b00) begin
      level = fmvsw_pkg::LEVEL_MAX;
    end else begin
      level = diff[6:0];
    end
  end

  always_comb begin
    beat.last_write = cmd.last;
    case (cmd.sel)
      fmvsw_pkg::LOAD_PASS: begin
        beat.out_addr = addr_q;
        beat.out_data = data_q;
      end
      fmvsw_pkg::LOAD_MIX: begin
        beat.out_addr = fmvsw_pkg::MIXER_ADDR;
        beat.out_data = mute_q ? fmvsw_pkg::MIXER_MUTE : mixer_shadow;
      end
      default: begin
        beat.out_addr = {ch_sel[2], fmvsw_pkg::TL_GROUP, cmd.slot, ch_sel[1:0]};
        beat.out_data = {1'b0, level};
      end
    endcase
  end

  assign sts.enable   = chip_enable;
  assign sts.out_free = !wr_valid || !wr_stall;
  assign sts.mask_bit = mask[cmd.slot];

  always_ff @(posedge clk) begin
    if (rst) begin
      chip_enable <= 1'b0;
    end else if (cfg_wr_en) begin
      chip_enable <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mixer_shadow <= fmvsw_pkg::MIXER_RESET;
      for (int i = 0; i < 32; i++) begin
        tl_shadow[i] <= fmvsw_pkg::TL_RESET;
      end
      for (int i = 0; i < 8; i++) begin
        alg_shadow[i] <= 8'h00;
      end
    end else if (cmd.shadow_wr) begin
      if (req.reg_addr == fmvsw_pkg::MIXER_ADDR) begin
        mixer_shadow <= req.reg_data;
      end else if (req.reg_addr[7:4] == fmvsw_pkg::TL_GROUP) begin
        tl_shadow[{req.reg_addr[8], req.reg_addr[3:0]}] <= req.reg_data;
      end else if (req.reg_addr[7:2] == fmvsw_pkg::ALG_GROUP) begin
        alg_shadow[{req.reg_addr[8], req.reg_addr[1:0]}] <= req.reg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      addr_q <= req.reg_addr;
      data_q <= req.reg_data;
      ch_q   <= req.channel;
      vol_q  <= req.volume;
      mute_q <= req.mute_on;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_valid <= 1'b0;
    end else if (cmd.load) begin
      wr_valid <= 1'b1;
    end else if (!wr_stall) begin
      wr_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      wr <= beat;
    end
  end

endmodule

`default_nettype wire

### rtl/fm_chip_volume_shadow_writer.sv
// Top level of the FM chip volume shadow writer.
// First write: the PASS, MIX or SLOT state entered on the request loads the first
// chip write beat once the output is free; set volume first skips non-carrier slots.
// Requests: one at a time; a register write passes through the PASS state, set volume
// walks the four slots of its channel, writing each carrier slot, and mute writes the
// mixer and then walks the four slots of six channels; output stalls hold any of them.
// The output register lets the next request be taken while the last beat waits.
// Reset: synchronous; clears the enable, restores all shadows and empties the output.
`default_nettype none

module fm_chip_volume_shadow_writer (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_wr_en,
  input  wire logic                 cfg_wr_data,
  input  wire logic                 req_valid,
  output logic                      req_stall,
  input  wire fmvsw_pkg::req_beat_t req,
  output logic                      wr_valid,
  input  wire logic                 wr_stall,
  output fmvsw_pkg::wr_beat_t       wr
);

  fmvsw_pkg::cmd_t cmd;
  fmvsw_pkg::sts_t sts;

  fmvsw_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_type  (req.req_type),
    .req_stall (req_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  fmvsw_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .req         (req),
    .cmd         (cmd),
    .sts         (sts),
    .wr_valid    (wr_valid),
    .wr_stall    (wr_stall),
    .wr          (wr)
  );

endmodule

`default_nettype wire

### rtl/fmvsw_checker.sv
// Port-level assertions for the FM chip volume shadow writer, bound to the top level.
`default_nettype none

module fmvsw_checker (
  input wire logic                 clk,
  input wire logic                 rst,
  input wire logic                 cfg_wr_en,
  input wire logic                 cfg_wr_data,
  input wire logic                 req_valid,
  input wire logic                 req_stall,
  input wire fmvsw_pkg::req_beat_t req,
  input wire logic                 wr_valid,
  input wire logic                 wr_stall,
  input wire fmvsw_pkg::wr_beat_t  wr
);

  logic en;
  logic req_take;
  logic req_live;

  assign req_take = req_valid && !req_stall;
  assign req_live = req.req_type == fmvsw_pkg::REQ_WRITE ||
                    req.req_type == fmvsw_pkg::REQ_VOLUME ||
                    req.req_type == fmvsw_pkg::REQ_MUTE;

  always_ff @(posedge clk) begin
    if (rst) begin
      en <= 1'b0;
    end else if (cfg_wr_en) begin
      en <= cfg_wr_data;
    end
  end

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !wr_valid && !req_stall)
    else $error("output or input side busy after reset");

  a_wr_hold: assert property (@(posedge clk) disable iff (rst)
    wr_valid && wr_stall |=> wr_valid && $stable(wr))
    else $error("stalled write beat changed");

  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    req_take && en && req_live |=> req_stall)
    else $error("live request did not hold off the next beat");

  a_drop_when_off: assert property (@(posedge clk) disable iff (rst)
    req_take && (!en || !req_live) |=> !req_stall)
    else $error("dropped request left the block busy");

endmodule

bind fm_chip_volume_shadow_writer fmvsw_checker u_fmvsw_checker (
  .clk         (clk),
  .rst         (rst),
  .cfg_wr_en   (cfg_wr_en),
  .cfg_wr_data (cfg_wr_data),
  .req_valid   (req_valid),
  .req_stall   (req_stall),
  .req         (req),
  .wr_valid    (wr_valid),
  .wr_stall    (wr_stall),
  .wr          (wr)
);

`default_nettype wire

### bench/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for the FM chip volume shadow writer: directed and random requests.
module tb;
  import fmvsw_pkg::*;

  localparam int CYCLE_LIMIT = 800000;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES = 300;
  localparam int MAX_IDLE = 18;
  localparam int MAX_SHOWN = 10;

  localparam logic [1:0] REQ_NONE = 2'd3;
  localparam logic [31:0] CARRIER_MASKS = 32'hFEEC_8888;
  localparam logic [8:0] MIXER_REG = 9'h007;
  localparam logic [8:0] TL_PORT0 = 9'h040;
  localparam logic [8:0] TL_PORT1 = 9'h140;
  localparam logic [3:0] TL_NIBBLE = 4'h4;
  localparam logic [5:0] ALG_BITS = 6'b101100;
  localparam logic [7:0] TL_INIT = 8'h7F;
  localparam logic [7:0] MIXER_INIT = 8'h3F;
  localparam logic [7:0] MIXER_MUTED = 8'h3F;
  localparam int MUTE_ATTEN = -127;
  localparam int LEVEL_TOP = 127;

  typedef enum logic [1:0] {STEP_REQ, STEP_CFG, STEP_DRAIN, STEP_HOLD} step_kind_e;

  typedef struct packed {
    step_kind_e kind;
    logic       en;
    req_beat_t  beat;
  } step_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr_en = 1'b0;
  logic cfg_wr_data = 1'b0;
  logic req_valid = 1'b0;
  logic req_stall;
  req_beat_t req = '0;
  logic wr_valid;
  logic wr_stall = 1'b0;
  wr_beat_t wr;

  step_t steps[$];
  wr_beat_t due_writes[$];

  logic enable_copy;
  logic [7:0] tl_copy [32];
  logic [7:0] alg_copy [8];
  logic [7:0] mixer_copy;

  logic req_fire = 1'b0;
  logic wr_fire = 1'b0;
  int mismatches = 0;
  int src_gap = 0;
  bit src_idle_on = 1'b1;
  int quiet_cycles = 0;
  int hold_requests = 0;
  int hold_served = 0;
  int hold_left = 0;
  int snk_wait = 0;
  bit snk_idle_on = 1'b1;

  fm_chip_volume_shadow_writer uut (
    .clk(clk),
    .rst(rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req(req),
    .wr_valid(wr_valid),
    .wr_stall(wr_stall),
    .wr(wr)
  );

  always #1 clk = ~clk;

  function automatic logic [7:0] attenuate(input logic [7:0] tl, input int vol);
    int level;
    level = int'(tl[6:0]) - vol;
    if (level < 0) begin
      level = 0;
    end else if (level > LEVEL_TOP) begin
      level = LEVEL_TOP;
    end
    return level[7:0];
  endfunction

  task automatic push_write(input logic [8:0] addr, input logic [7:0] data);
    wr_beat_t w;
    w.out_addr = addr;
    w.out_data = data;
    w.last_write = 1'b0;
    due_writes.push_back(w);
  endtask

  task automatic derive_channel_levels(input logic [2:0] ch, input int vol);
    logic [3:0] mask;
    logic [3:0] off;
    int s;
    mask = CARRIER_MASKS[{alg_copy[ch][2:0], 2'b00} +: 4];
    for (s = 0; s < 4; s++) begin
      off = {s[1:0], ch[1:0]};
      if (mask[s]) begin
        push_write((ch[2] ? TL_PORT1 : TL_PORT0) + off, attenuate(tl_copy[{ch[2], off}], vol));
      end
    end
  endtask

  task automatic derive_chip_writes(input req_beat_t r);
    int start_count;
    int mute_vol;
    int c;
    wr_beat_t closing;
    start_count = due_writes.size();
    if (enable_copy) begin
      case (r.req_type)
        REQ_WRITE: begin
          if (r.reg_addr == MIXER_REG) begin
            mixer_copy = r.reg_data;
          end else if (r.reg_addr[7:4] == TL_NIBBLE) begin
            tl_copy[{r.reg_addr[8], r.reg_addr[3:0]}] = r.reg_data;
          end else if (r.reg_addr[7:2] == ALG_BITS) begin
            alg_copy[{r.reg_addr[8], r.reg_addr[1:0]}] = r.reg_data;
          end
          push_write(r.reg_addr, r.reg_data);
        end
        REQ_VOLUME: begin
          derive_channel_levels(r.channel, int'($signed(r.volume)));
        end
        REQ_MUTE: begin
          mute_vol = r.mute_on ? MUTE_ATTEN : 0;
          push_write(MIXER_REG, r.mute_on ? MIXER_MUTED : mixer_copy);
          for (c = 0; c < 3; c++) begin
            derive_channel_levels({1'b0, c[1:0]}, mute_vol);
            derive_channel_levels({1'b1, c[1:0]}, mute_vol);
          end
        end
        default: begin
        end
      endcase
    end
    if (due_writes.size() > start_count) begin
      closing = due_writes.pop_back();
      closing.last_write = 1'b1;
      due_writes.push_back(closing);
    end
  endtask

  task automatic report_write(input wr_beat_t want, input bit have_want);
    mismatches++;
    if (mismatches <= MAX_SHOWN) begin
      if (have_want) begin
        $display("mismatch: expected addr %h data %h last %b, got addr %h data %h last %b",
                 want.out_addr, want.out_data, want.last_write,
                 wr.out_addr, wr.out_data, wr.last_write);
      end else begin
        $display("mismatch: unexpected write addr %h data %h last %b",
                 wr.out_addr, wr.out_data, wr.last_write);
      end
    end
  endtask

  always @(posedge clk) begin
    wr_beat_t want;
    int i;
    req_fire = req_valid && !req_stall && !rst;
    wr_fire = wr_valid && !wr_stall && !rst;
    if (rst) begin
      enable_copy = 1'b0;
      for (i = 0; i < 32; i++) begin
        tl_copy[i] = TL_INIT;
      end
      for (i = 0; i < 8; i++) begin
        alg_copy[i] = 8'h00;
      end
      mixer_copy = MIXER_INIT;
    end else begin
      if (cfg_wr_en) begin
        enable_copy = cfg_wr_data;
      end
      if (wr_fire) begin
        if (due_writes.size() == 0) begin
          report_write(wr, 1'b0);
        end else begin
          want = due_writes.pop_front();
          if (wr.out_addr !== want.out_addr || wr.out_data !== want.out_data ||
              wr.last_write !== want.last_write) begin
            report_write(want, 1'b1);
          end
        end
      end
      if (req_fire) begin
        derive_chip_writes(req);
      end
    end
  end

  always @(negedge clk) begin
    step_t s;
    logic next_valid;
    req_beat_t next_req;
    logic next_cfg;
    next_valid = req_valid;
    next_req = req;
    next_cfg = 1'b0;
    if (due_writes.size() != 0 || req_valid) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (!rst && (!req_valid || req_fire)) begin
      next_valid = 1'b0;
      if (src_gap > 0) begin
        src_gap--;
      end else if (steps.size() != 0) begin
        s = steps[0];
        case (s.kind)
          STEP_REQ: begin
            s = steps.pop_front();
            next_valid = 1'b1;
            next_req = s.beat;
            if ($urandom_range(0, 39) == 0) begin
              src_idle_on = !src_idle_on;
            end
            src_gap = src_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
          end
          STEP_CFG: begin
            if (quiet_cycles >= SETTLE_CYCLES) begin
              s = steps.pop_front();
              next_cfg = 1'b1;
              cfg_wr_data <= s.en;
            end
          end
          STEP_DRAIN: begin
            if (due_writes.size() == 0) begin
              s = steps.pop_front();
            end
          end
          default: begin
            s = steps.pop_front();
            hold_requests++;
          end
        endcase
      end
    end
    req_valid <= next_valid;
    req <= next_req;
    cfg_wr_en <= next_cfg;
  end

  always @(negedge clk) begin
    logic next_stall;
    if (hold_served != hold_requests) begin
      hold_served++;
      hold_left = HOLD_CYCLES;
    end
    if (wr_fire) begin
      if ($urandom_range(0, 49) == 0) begin
        snk_idle_on = !snk_idle_on;
      end
      snk_wait = snk_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      next_stall = 1'b1;
    end else if (snk_wait > 0 && wr_valid === 1'b1) begin
      snk_wait--;
      next_stall = 1'b1;
    end else begin
      next_stall = 1'b0;
    end
    wr_stall <= next_stall;
  end

  function automatic req_beat_t make_req(input logic [1:0] kind, input logic [8:0] addr,
                                         input logic [7:0] data, input logic [2:0] ch,
                                         input logic [7:0] vol, input logic mute);
    req_beat_t b;
    b.req_type = kind;
    b.reg_addr = addr;
    b.reg_data = data;
    b.channel = ch;
    b.volume = vol;
    b.mute_on = mute;
    return b;
  endfunction

  function automatic req_beat_t random_req();
    logic [31:0] bits;
    logic [8:0] addr;
    req_beat_t b;
    int pick;
    bits = $urandom;
    b = bits[30:0];
    addr = b.reg_addr;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      b.req_type = REQ_WRITE;
      case ($urandom_range(0, 5))
        0: addr = {addr[8], MIXER_REG[7:0]};
        1, 2: addr[7:4] = TL_NIBBLE;
        3: addr[7:2] = ALG_BITS;
        default: begin
        end
      endcase
      b.reg_addr = addr;
    end else if (pick < 85) begin
      b.req_type = REQ_VOLUME;
      if ($urandom_range(0, 4) == 0) begin
        b.volume = $urandom_range(0, 1) ? 8'h80 : 8'h7F;
      end
    end else if (pick < 95) begin
      b.req_type = REQ_MUTE;
    end else begin
      b.req_type = REQ_NONE;
    end
    return b;
  endfunction

  task automatic push_req(input req_beat_t b);
    step_t s;
    s.kind = STEP_REQ;
    s.en = 1'b0;
    s.beat = b;
    steps.push_back(s);
  endtask

  task automatic push_cfg(input logic en);
    step_t s;
    s.kind = STEP_CFG;
    s.en = en;
    s.beat = '0;
    steps.push_back(s);
  endtask

  task automatic push_ctl(input step_kind_e kind);
    step_t s;
    s.kind = kind;
    s.en = 1'b0;
    s.beat = '0;
    steps.push_back(s);
  endtask

  task automatic push_random(input int count);
    int i;
    for (i = 0; i < count; i++) begin
      push_req(random_req());
    end
  endtask

  initial begin
    push_cfg(1'b0);
    push_req(make_req(REQ_WRITE, 9'h040, 8'h00, 3'd0, 8'h00, 1'b0));
    push_req(make_req(REQ_VOLUME, 9'h000, 8'h00, 3'd0, 8'h10, 1'b0));
    push_req(make_req(REQ_MUTE, 9'h000, 8'h00, 3'd0, 8'h00, 1'b1));
    push_cfg(1'b1);
    push_req(make_req(REQ_WRITE, 9'h007, 8'h2A, 3'd0, 8'h00, 1'b0));
    push_req(make_req(REQ_WRITE, 9'h107, 8'h15, 3'd0, 8'h00, 1'b0));
    push_req(make_req(REQ_WRITE, 9'h040, 8'h00, 3'd0, 8'h00, 1'b0));
    push_req(make_req(REQ_WRITE, 9'h04F, 8'hFF, 3'd0, 8'h00, 1'b0));
    push_req(make_req(REQ_WRITE, 9'h14C, 8'h10, 3'd0, 8'h00, 1'b0));
    push_req(make_req(REQ_WRITE, 9'h0B3, 8'h07, 3'd0, 8'h00, 1'b0));
    push_req(make_req(REQ_WRITE, 9'h1B3, 8'h05, 3'd0, 8'h00, 1'b0));
    push_req(make_req(REQ_WRITE, 9'h0B0, 8'h04, 3'd0, 8'h00, 1'b0));
    push_req(make_req(REQ_VOLUME, 9'h000, 8'h00, 3'd3, 8'h7F, 1'b0));
    push_req(make_req(REQ_VOLUME, 9'h000, 8'h00, 3'd3, 8'h80, 1'b0));
    push_req(make_req(REQ_VOLUME, 9'h000, 8'h00, 3'd7, 8'h05, 1'b0));
    push_req(make_req(REQ_VOLUME, 9'h000, 8'h00, 3'd0, 8'h00, 1'b0));
    push_req(make_req(REQ_VOLUME, 9'h000, 8'h00, 3'd4, 8'hFF, 1'b0));
    push_req(make_req(REQ_VOLUME, 9'h000, 8'h00, 3'd1, 8'h80, 1'b0));
    push_req(make_req(REQ_MUTE, 9'h000, 8'h00, 3'd0, 8'h00, 1'b1));
    push_req(make_req(REQ_MUTE, 9'h1FF, 8'hFF, 3'd7, 8'hFF, 1'b0));
    push_req(make_req(REQ_NONE, 9'h1FF, 8'hFF, 3'd7, 8'hFF, 1'b1));
    push_req(make_req(REQ_WRITE, 9'h1FF, 8'hFF, 3'd7, 8'hFF, 1'b1));
    push_req(make_req(REQ_WRITE, 9'h000, 8'h00, 3'd0, 8'h00, 1'b0));
    push_random(90);
    push_ctl(STEP_HOLD);
    push_random(20);
    push_ctl(STEP_DRAIN);
    push_random(60);
    push_cfg(1'b0);
    push_random(20);
    push_cfg(1'b1);
    push_random(60);

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    while (steps.size() != 0 || req_valid || due_writes.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("tb: FAIL");
    $finish;
  end

endmodule

### fm_chip_volume_shadow_writer.f
rtl/fmvsw_pkg.sv
rtl/fmvsw_ctrl.sv
rtl/fmvsw_datapath.sv
rtl/fm_chip_volume_shadow_writer.sv
rtl/fmvsw_checker.sv
bench/tb.sv
